>>> hw/rtl/gmps_pkg.sv
// Shared types and fixed field widths for the grid max-path score block.
// No dependencies; imported by the top level and by its port checker.
`timescale 1ns / 1ps

package gmps_pkg;

  // Fixed widths of the stream and configuration fields.
  localparam int CFG_W       = 6;   // grid_size
  localparam int CELL_W      = 16;  // cell_value, path_value
  localparam int COORD_W     = 6;   // path_row, path_col
  localparam int TOTAL_W     = 24;  // best_total
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_FIELDS_W = 2 * COORD_W + CELL_W + TOTAL_W;
  localparam int OUT_TDATA_W = 56;

  // Grid size after reset.
  localparam int GRID_RESET = 4;

  typedef enum logic [3:0] {
    ST_LOAD,      // waiting for the next cell
    ST_CALC,      // score of the accepted cell is formed and written
    ST_TB_PUSH,   // record the current traceback cell, pick the next step
    ST_TB_UP,     // score above is back, fetch the one to the left
    ST_TB_LEFT,   // score to the left is back, fetch the diagonal
    ST_TB_DIAG,   // all three scores known, take the step
    ST_EM_STACK,  // fetch the next path cell from the stack
    ST_EM_VALUE,  // fetch its grid value
    ST_EM_OUT     // load the output word
  } state_t;

endpackage

>>> hw/rtl/grid_max_path_score_dp.sv
// Top level of the grid max-path score block: scoring, traceback and path output.
// Depends on gmps_pkg for field widths and the sequencer state type.
`timescale 1ns / 1ps

// Usage
// Cells of an N by N signed grid arrive on the s_axis channel in row-major order,
// one 16-bit cell_value per word. A write on the cfg channel sets N (grid_size) and
// restarts loading at the top-left cell; write it only while the block is idle.
// Each cell first fetches the score above from the score memory, then forms the
// best score and writes it back. The left and diagonal scores are kept in
// registers, so only the score above is read through the single score read port.
// After the last cell the block traces back from the bottom-right corner; a step
// along an edge reads no scores, an inner step makes three reads through the same
// score port, and the path holds up to 2N-1 cells. It then sends the path from the
// top-left to the bottom-right corner on m_axis, one word per cell, each word taking
// a stack read, a value read and an output load; tlast marks the bottom-right cell.
// s_axis_tready is low from the last cell until the last path word is loaded.
// The output register holds a word until it is taken; a stalled receiver halts the
// path output, and new cells are accepted while the final word still waits.
// Reset sets N to 4 and clears the control state; there is no clearing pass, the
// memories hold nothing defined until a grid has been loaded.
module grid_max_path_score_dp
  import gmps_pkg::*;
#(
  parameter int MAX_SIZE   = 32,
  parameter int VALUE_BITS = 16,
  parameter int SCORE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data,       // grid_size
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // cell_value
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // path_row, path_col, path_value,
                                                 // best_total, zero fill
  output logic                   m_axis_tlast    // path_last
);

  localparam int ROW_BITS  = $clog2(MAX_SIZE);
  localparam int ADDR_BITS = 2 * ROW_BITS;
  localparam int DEPTH     = 1 << ADDR_BITS;
  localparam int STK_DEPTH = 2 * MAX_SIZE - 1;
  localparam int STK_BITS  = $clog2(STK_DEPTH);
  localparam int VW        = (VALUE_BITS > CELL_W) ? VALUE_BITS : CELL_W;
  localparam int SUM_BITS  = ((VALUE_BITS > SCORE_BITS) ? VALUE_BITS : SCORE_BITS) + 1;
  localparam int TW        = (SCORE_BITS > TOTAL_W) ? SCORE_BITS : TOTAL_W;

  localparam logic [ROW_BITS-1:0] RST_LAST =
    ROW_BITS'(((GRID_RESET > MAX_SIZE) ? MAX_SIZE : GRID_RESET) - 1);

  localparam logic signed [VW-1:0] VL_MAX =
    VW'($signed({1'b0, {(VALUE_BITS-1){1'b1}}}));
  localparam logic signed [VW-1:0] VL_MIN =
    VW'($signed({1'b1, {(VALUE_BITS-1){1'b0}}}));
  localparam logic signed [SUM_BITS-1:0] SC_MAX =
    SUM_BITS'($signed({1'b0, {(SCORE_BITS-1){1'b1}}}));
  localparam logic signed [SUM_BITS-1:0] SC_MIN =
    SUM_BITS'($signed({1'b1, {(SCORE_BITS-1){1'b0}}}));
  localparam logic signed [TW-1:0] TT_MAX =
    TW'($signed({1'b0, {(TOTAL_W-1){1'b1}}}));
  localparam logic signed [TW-1:0] TT_MIN =
    TW'($signed({1'b1, {(TOTAL_W-1){1'b0}}}));

  state_t state, state_next;

  // Control registers.
  logic [ROW_BITS-1:0] last_idx;
  logic [ROW_BITS-1:0] load_row, load_col;
  logic [ROW_BITS-1:0] tb_row, tb_col;
  logic [STK_BITS-1:0] sp;
  logic [STK_BITS-1:0] emit_idx;
  logic                out_valid;

  // Payload registers.
  logic signed [VALUE_BITS-1:0] cell_v;
  logic signed [SCORE_BITS-1:0] left_q, diag_q, ld_best;
  logic signed [SCORE_BITS-1:0] tb_up, tb_left;
  logic signed [TOTAL_W-1:0]    total_q;
  logic [ADDR_BITS-1:0]         emit_addr;
  logic [COORD_W-1:0]           out_row, out_col;
  logic [CELL_W-1:0]            out_value;
  logic [TOTAL_W-1:0]           out_total;
  logic                         out_last;

  // Memories and their registered read data.
  logic [VALUE_BITS-1:0] value_mem [DEPTH];
  logic [SCORE_BITS-1:0] score_mem [DEPTH];
  logic [ADDR_BITS-1:0]  stack_mem [STK_DEPTH];
  logic signed [VALUE_BITS-1:0] value_q;
  logic signed [SCORE_BITS-1:0] score_q;
  logic [ADDR_BITS-1:0]         stack_q;

  // Sequencer outputs.
  logic                 score_re, value_re, stack_re;
  logic                 store_we, stack_we, out_load;
  logic [ADDR_BITS-1:0] score_ra;

  logic                 in_accept, last_cell, tb_home;
  logic [ROW_BITS-1:0]  cfg_last;
  logic signed [VW-1:0]         in_ext;
  logic signed [VALUE_BITS-1:0] in_sat;
  logic signed [SCORE_BITS-1:0] addend;
  logic signed [SUM_BITS-1:0]   sum;
  logic signed [SCORE_BITS-1:0] score_new;
  logic signed [TW-1:0]         total_ext;
  logic signed [TOTAL_W-1:0]    total_sat;

  assign cfg_ready     = 1'b1;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign last_cell     = (load_row == last_idx) && (load_col == last_idx);
  assign tb_home       = (tb_row == '0) && (tb_col == '0);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                          out_total, out_value, out_col, out_row};

  // A size of zero acts as one, anything above the maximum as the maximum.
  always_comb begin
    if (cfg_data == '0) begin
      cfg_last = '0;
    end else if (cfg_data > CFG_W'(MAX_SIZE)) begin
      cfg_last = ROW_BITS'(MAX_SIZE - 1);
    end else begin
      cfg_last = ROW_BITS'(cfg_data - CFG_W'(1));
    end
  end

  // Input value clamped into the stored value range.
  always_comb begin
    in_ext = VW'($signed(s_axis_tdata));
    if (in_ext > VL_MAX) begin
      in_sat = VALUE_BITS'(VL_MAX);
    end else if (in_ext < VL_MIN) begin
      in_sat = VALUE_BITS'(VL_MIN);
    end else begin
      in_sat = VALUE_BITS'(in_ext);
    end
  end

  // Best predecessor plus cell value, saturated to the score range.
  // score_q holds the score above, ld_best the larger of left and diagonal.
  always_comb begin
    if (load_row == '0 && load_col == '0) begin
      addend = '0;
    end else if (load_row == '0) begin
      addend = left_q;
    end else if (load_col == '0) begin
      addend = score_q;
    end else begin
      addend = (score_q > ld_best) ? score_q : ld_best;
    end
    sum = SUM_BITS'(cell_v) + SUM_BITS'(addend);
    if (sum > SC_MAX) begin
      score_new = SCORE_BITS'(SC_MAX);
    end else if (sum < SC_MIN) begin
      score_new = SCORE_BITS'(SC_MIN);
    end else begin
      score_new = SCORE_BITS'(sum);
    end
    total_ext = TW'(score_new);
    if (total_ext > TT_MAX) begin
      total_sat = TOTAL_W'(TT_MAX);
    end else if (total_ext < TT_MIN) begin
      total_sat = TOTAL_W'(TT_MIN);
    end else begin
      total_sat = TOTAL_W'(total_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    score_re      = 1'b0;
    score_ra      = {load_row - ROW_BITS'(1), load_col};
    value_re      = 1'b0;
    stack_re      = 1'b0;
    store_we      = 1'b0;
    stack_we      = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_LOAD: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          score_re   = (load_row != '0);
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        store_we   = 1'b1;
        state_next = last_cell ? ST_TB_PUSH : ST_LOAD;
      end
      ST_TB_PUSH: begin
        stack_we = 1'b1;
        score_ra = {tb_row - ROW_BITS'(1), tb_col};
        if (tb_home) begin
          state_next = ST_EM_STACK;
        end else if (tb_row != '0 && tb_col != '0) begin
          score_re   = 1'b1;
          state_next = ST_TB_UP;
        end
      end
      ST_TB_UP: begin
        score_re   = 1'b1;
        score_ra   = {tb_row, tb_col - ROW_BITS'(1)};
        state_next = ST_TB_LEFT;
      end
      ST_TB_LEFT: begin
        score_re   = 1'b1;
        score_ra   = {tb_row - ROW_BITS'(1), tb_col - ROW_BITS'(1)};
        state_next = ST_TB_DIAG;
      end
      ST_TB_DIAG: begin
        state_next = ST_TB_PUSH;
      end
      ST_EM_STACK: begin
        stack_re   = 1'b1;
        state_next = ST_EM_VALUE;
      end
      ST_EM_VALUE: begin
        value_re   = 1'b1;
        state_next = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        if (!out_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = (emit_idx == '0) ? ST_LOAD : ST_EM_STACK;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_idx  <= RST_LAST;
      load_row  <= '0;
      load_col  <= '0;
      tb_row    <= '0;
      tb_col    <= '0;
      sp        <= '0;
      emit_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (store_we) begin
        if (load_col == last_idx) begin
          load_col <= '0;
          load_row <= (load_row == last_idx) ? '0 : load_row + ROW_BITS'(1);
        end else begin
          load_col <= load_col + ROW_BITS'(1);
        end
        if (last_cell) begin
          tb_row <= last_idx;
          tb_col <= last_idx;
          sp     <= '0;
        end
      end
      if (cfg_valid && cfg_ready) begin
        last_idx <= cfg_last;
        load_row <= '0;
        load_col <= '0;
      end
      if (stack_we) begin
        sp <= sp + STK_BITS'(1);
        if (tb_home) begin
          emit_idx <= sp;
        end else if (tb_row == '0) begin
          tb_col <= tb_col - ROW_BITS'(1);
        end else if (tb_col == '0) begin
          tb_row <= tb_row - ROW_BITS'(1);
        end
      end
      // Ties go to the cell above first, then to the left.
      if (state == ST_TB_DIAG) begin
        if (tb_up >= tb_left && tb_up >= score_q) begin
          tb_row <= tb_row - ROW_BITS'(1);
        end else if (tb_left >= score_q) begin
          tb_col <= tb_col - ROW_BITS'(1);
        end else begin
          tb_row <= tb_row - ROW_BITS'(1);
          tb_col <= tb_col - ROW_BITS'(1);
        end
      end
      if (out_load && emit_idx != '0) begin
        emit_idx <= emit_idx - STK_BITS'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cell_v  <= in_sat;
      ld_best <= (left_q > diag_q) ? left_q : diag_q;
    end
    if (store_we) begin
      left_q <= score_new;
      diag_q <= score_q;
      if (last_cell) begin
        total_q <= total_sat;
      end
    end
    if (state == ST_TB_UP) begin
      tb_up <= score_q;
    end
    if (state == ST_TB_LEFT) begin
      tb_left <= score_q;
    end
    if (value_re) begin
      emit_addr <= stack_q;
    end
    if (out_load) begin
      out_row   <= COORD_W'(emit_addr[ADDR_BITS-1:ROW_BITS]) + COORD_W'(1);
      out_col   <= COORD_W'(emit_addr[ROW_BITS-1:0]) + COORD_W'(1);
      out_value <= CELL_W'(VW'(value_q));
      out_total <= total_q;
      out_last  <= (emit_idx == '0);
    end
  end

  // Score memory: one write and one read per cycle.
  always_ff @(posedge clk) begin
    if (store_we) begin
      score_mem[{load_row, load_col}] <= score_new;
    end
    if (score_re) begin
      score_q <= score_mem[score_ra];
    end
  end

  // Value memory, read only while the path goes out.
  always_ff @(posedge clk) begin
    if (store_we) begin
      value_mem[{load_row, load_col}] <= cell_v;
    end
    if (value_re) begin
      value_q <= value_mem[stack_q];
    end
  end

  // Traceback stack, filled from the bottom-right corner and read back in reverse.
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[sp] <= {tb_row, tb_col};
    end
    if (stack_re) begin
      stack_q <= stack_mem[emit_idx];
    end
  end

endmodule

>>> hw/rtl/gmps_checker.sv
// Port-level checker for the grid max-path score block, bound to its top level.
// Depends on gmps_pkg for the stream field widths.
`timescale 1ns / 1ps

module gmps_checker
  import gmps_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  // A stalled output word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // After a cell is taken, s_axis_tready drops before the next one can be taken.
  a_cell_two_cycles: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("cell accepted in back-to-back cycles");

  // While a path is partly sent, no new cell is taken.
  a_no_load_mid_path: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("cell accepted in the middle of a path");

  // Path coordinates count from one.
  a_coords_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[5:0] != '0) && (m_axis_tdata[11:6] != '0))
    else $error("path coordinate of zero");

endmodule

bind grid_max_path_score_dp gmps_checker u_gmps_checker (.*);
